FILE: src/h2r_pkg.sv
// Shared types, constants and helper functions for the HLS to RGB converter.
// No dependencies; imported by h2r_chan and hls_to_rgb_converter.
`default_nettype none

package h2r_pkg;

	// Hue breakpoints in 1/16 degree units
	localparam logic [13:0] HUE_FULL = 14'd5760;
	localparam logic [13:0] HUE_60   = 14'd960;
	localparam logic [13:0] HUE_180  = 14'd2880;
	localparam logic [13:0] HUE_240  = 14'd3840;
	localparam logic [13:0] HUE_120  = 14'd1920;

	localparam logic [16:0] Q_HALF = 17'd32768;

	// floor(x/960) = floor(floor(x/64)/15); the divide by 15 runs on a biased,
	// non-negative value through a reciprocal multiply.
	localparam logic [25:0] DIV_BIAS  = 26'd31457280; // 15 * 2^21
	localparam logic [26:0] DIV_RECIP = 27'd71582789; // ceil(2^30 / 15)
	localparam logic [23:0] QUOT_OFS  = 24'd2097152;  // 2^21, bias after divide

	typedef enum logic [1:0] {
		REG_RISE,
		REG_HIGH,
		REG_FALL,
		REG_LOW
	} h2r_region_t;

	typedef struct packed {
		h2r_region_t region;
		logic [9:0]  dh;
	} h2r_hue_t;

	typedef struct packed {
		logic adv_s3;
		logic adv_s4;
		logic adv_s5;
	} h2r_adv_t;

	// Pick the ramp segment and the distance into it for one channel hue.
	function automatic h2r_hue_t hue_split(input logic [12:0] hue, input logic [13:0] ofs);
		logic [13:0] h;
		logic [13:0] fall;
		h2r_hue_t    r;
		h = {1'b0, hue} + ofs;
		if (h > HUE_FULL) begin
			h = h - HUE_FULL;
		end
		fall = HUE_240 - h;
		if (h < HUE_60) begin
			r.region = REG_RISE;
			r.dh     = h[9:0];
		end else if (h < HUE_180) begin
			r.region = REG_HIGH;
			r.dh     = '0;
		end else if (h < HUE_240) begin
			r.region = REG_FALL;
			r.dh     = fall[9:0];
		end else begin
			r.region = REG_LOW;
			r.dh     = '0;
		end
		return r;
	endfunction

	// Q16 value to 16-bit level: clamp at both ends, v*65535>>16 is v-1 inside.
	function automatic logic [15:0] to_level(input logic signed [23:0] v);
		logic [15:0] r;
		if (v <= 24'sd0) begin
			r = 16'd0;
		end else if (v >= 24'sd65536) begin
			r = 16'hFFFF;
		end else begin
			r = v[15:0] - 16'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/h2r_chan.sv
// One color channel of the HLS to RGB pipeline: stages 3 to 5 of the ramp.
// Depends on h2r_pkg; instantiated three times by hls_to_rgb_converter.
`default_nettype none

module h2r_chan import h2r_pkg::*; (
	input  wire logic               clk,
	input  wire h2r_adv_t           adv,
	input  wire h2r_region_t        region_s2,
	input  wire logic [9:0]         dh_s2,
	input  wire logic signed [20:0] d_s2,
	input  wire logic signed [19:0] m1_s2,
	input  wire logic signed [19:0] m2_s2,
	input  wire logic               gray_s4,
	input  wire logic [15:0]        gray_lvl_s4,
	output logic [15:0]             level
);

	logic signed [31:0] prod_s3;
	h2r_region_t        region_s3, region_s4;
	logic signed [19:0] m1_s3, m2_s3, m1_s4, m2_s4;
	logic [22:0]        quot_s4;

	logic [25:0]        biased;
	logic [52:0]        recip_full;
	logic signed [23:0] ramp_v;

	// Stage 3: slope times distance into the segment
	always_ff @(posedge clk) begin
		if (adv.adv_s3) begin
			prod_s3   <= 32'(d_s2) * $signed({22'b0, dh_s2});
			region_s3 <= region_s2;
			m1_s3     <= m1_s2;
			m2_s3     <= m2_s2;
		end
	end

	// Stage 4: floor divide by 960 as shift by 6, then reciprocal of 15
	assign biased     = prod_s3[31:6] + DIV_BIAS;
	assign recip_full = {27'b0, biased} * {26'b0, DIV_RECIP};

	always_ff @(posedge clk) begin
		if (adv.adv_s4) begin
			quot_s4   <= recip_full[52:30];
			region_s4 <= region_s3;
			m1_s4     <= m1_s3;
			m2_s4     <= m2_s3;
		end
	end

	// Stage 5: assemble the ramp value and clamp to a level
	always_comb begin
		case (region_s4)
			REG_RISE, REG_FALL: ramp_v = 24'(m1_s4) + $signed({1'b0, quot_s4})
				- $signed(QUOT_OFS);
			REG_HIGH:           ramp_v = 24'(m2_s4);
			REG_LOW:            ramp_v = 24'(m1_s4);
			default:            ramp_v = 24'(m1_s4);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.adv_s5) begin
			level <= gray_s4 ? gray_lvl_s4 : to_level(ramp_v);
		end
	end

endmodule

`default_nettype wire

FILE: src/hls_to_rgb_converter.sv
// HLS to RGB converter top level: input stages, m1/m2 forming, pipeline control.
// Depends on h2r_pkg and h2r_chan.
// An accepted item passes through stage registers s1 to s5 before it shows on out_valid.
// Throughput: one item per cycle while out_stall is low; five register stages, each a bubble-collapsing slot.
// Reset (arst_n low, asynchronous): all stage valid bits clear; payload is not reset.
`default_nettype none

module hls_to_rgb_converter import h2r_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [12:0] hue_sixteenths,
	input  wire logic [16:0] lightness_q16,
	input  wire logic [16:0] saturation_q16,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      red_level,
	output logic [15:0]      green_level,
	output logic [15:0]      blue_level
);

	// Pipeline control: a stage advances when empty or when the next one advances
	logic     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic     adv_s1, adv_s2;
	h2r_adv_t adv;

	assign adv.adv_s5 = !valid_s5 || !out_stall;
	assign adv.adv_s4 = !valid_s4 || adv.adv_s5;
	assign adv.adv_s3 = !valid_s3 || adv.adv_s4;
	assign adv_s2     = !valid_s2 || adv.adv_s3;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign in_stall   = !adv_s1;
	assign out_valid  = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s1)     valid_s1 <= in_valid;
			if (adv_s2)     valid_s2 <= valid_s1;
			if (adv.adv_s3) valid_s3 <= valid_s2;
			if (adv.adv_s4) valid_s4 <= valid_s3;
			if (adv.adv_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: L*S product, hue segment per channel, gray detect
	logic [33:0]  ls_full;
	logic [17:0]  p_s1;
	logic [16:0]  lig_s1, sat_s1;
	h2r_hue_t     hue_s1 [3];
	logic         gray_s1;
	logic [15:0]  gray_lvl_s1;

	assign ls_full = {17'b0, lightness_q16} * {17'b0, saturation_q16};

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			p_s1        <= ls_full[33:16];
			lig_s1      <= lightness_q16;
			sat_s1      <= saturation_q16;
			gray_s1     <= (saturation_q16 == 17'd0);
			gray_lvl_s1 <= to_level($signed({7'b0, lightness_q16}));
			// Channel hue offsets: hue zero is blue, so red sits at hue,
			// green at hue + 240 degrees and blue at hue + 120 degrees.
			hue_s1[0]   <= hue_split(hue_sixteenths, 14'd0);
			hue_s1[1]   <= hue_split(hue_sixteenths, HUE_240);
			hue_s1[2]   <= hue_split(hue_sixteenths, HUE_120);
		end
	end

	// Stage 2: m2 from the lightness branch, then m1 = 2L - m2 and slope m2 - m1
	logic [19:0]        m2_raw;
	logic signed [19:0] m2_c, m1_c;
	logic signed [20:0] d_c;
	logic signed [19:0] m1_s2, m2_s2;
	logic signed [20:0] d_s2;
	h2r_hue_t           hue_s2 [3];
	logic               gray_s2, gray_s3, gray_s4, gray_s5;
	logic [15:0]        gray_lvl_s2, gray_lvl_s3, gray_lvl_s4;

	always_comb begin
		if (lig_s1 <= Q_HALF) begin
			m2_raw = 20'(lig_s1) + 20'(p_s1);
		end else begin
			m2_raw = 20'(lig_s1) + 20'(sat_s1) - 20'(p_s1);
		end
		m2_c = $signed(m2_raw);
		m1_c = $signed({2'b0, lig_s1, 1'b0}) - m2_c;
		d_c  = 21'(m2_c) - 21'(m1_c);
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			m1_s2       <= m1_c;
			m2_s2       <= m2_c;
			d_s2        <= d_c;
			hue_s2      <= hue_s1;
			gray_s2     <= gray_s1;
			gray_lvl_s2 <= gray_lvl_s1;
		end
	end

	// Gray bypass travels alongside the channel stages
	always_ff @(posedge clk) begin
		if (adv.adv_s3) begin
			gray_s3     <= gray_s2;
			gray_lvl_s3 <= gray_lvl_s2;
		end
		if (adv.adv_s4) begin
			gray_s4     <= gray_s3;
			gray_lvl_s4 <= gray_lvl_s3;
		end
		if (adv.adv_s5) begin
			gray_s5 <= gray_s4;
		end
	end

	// Stages 3 to 5 run per channel
	logic [15:0] lvl [3];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		h2r_chan u_chan (
			.clk         (clk),
			.adv         (adv),
			.region_s2   (hue_s2[c].region),
			.dh_s2       (hue_s2[c].dh),
			.d_s2        (d_s2),
			.m1_s2       (m1_s2),
			.m2_s2       (m2_s2),
			.gray_s4     (gray_s4),
			.gray_lvl_s4 (gray_lvl_s4),
			.level       (lvl[c])
		);
	end

	assign red_level   = lvl[0];
	assign green_level = lvl[1];
	assign blue_level  = lvl[2];

	// An empty first stage must never push back on the input
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled while stage 1 is empty");

	// An accepted item lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item missing from stage 1");

	// A held stage 4 item stays put
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !adv.adv_s5 |=> valid_s4 && $stable(gray_s4))
		else $error("stage 4 item lost while held");

	// Zero saturation gives three equal levels
	a_gray_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gray_s5 |-> red_level == green_level && green_level == blue_level)
		else $error("gray item with unequal channels");

endmodule

`default_nettype wire
